// File: rtl/core/i2cee_pkg.sv
// shared types and constants for the i2c eeprom master
package i2cee_pkg;

    localparam int PAGE_BYTES = 5;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_BYTE_WRITE = 3'd1;
    localparam logic [2:0] CMD_PAGE_WRITE = 3'd2;
    localparam logic [2:0] CMD_RAND_READ  = 3'd3;
    localparam logic [2:0] CMD_SEQ_READ   = 3'd4;

    localparam logic [3:0] REG_DEVICE_ADDRESS = 4'd0;
    localparam logic [3:0] REG_WORD_ADDRESS   = 4'd1;
    localparam logic [3:0] REG_SINGLE_BYTE    = 4'd2;
    localparam logic [3:0] REG_PAGE_BYTE0     = 4'd3;
    localparam logic [3:0] REG_PAGE_BYTE1     = 4'd4;
    localparam logic [3:0] REG_PAGE_BYTE2     = 4'd5;
    localparam logic [3:0] REG_PAGE_BYTE3     = 4'd6;
    localparam logic [3:0] REG_PAGE_BYTE4     = 4'd7;

    localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd80;
    localparam logic [7:0] RST_WORD_ADDRESS   = 8'd85;
    localparam logic [7:0] RST_SINGLE_BYTE    = 8'd85;
    localparam logic [7:0] RST_PAGE_BYTE0     = 8'hF0;
    localparam logic [7:0] RST_PAGE_BYTE1     = 8'h0F;
    localparam logic [7:0] RST_PAGE_BYTE2     = 8'hAA;
    localparam logic [7:0] RST_PAGE_BYTE3     = 8'h55;
    localparam logic [7:0] RST_PAGE_BYTE4     = 8'h77;

    typedef struct packed {
        logic [6:0]                  device_address;
        logic [7:0]                  word_address;
        logic [7:0]                  single_byte;
        logic [PAGE_BYTES-1:0][7:0]  page_data;
    } i2cee_cfg_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic [2:0]  read_index;
        logic        ack_missing;
        logic [15:0] write_sum;
        logic [15:0] read_sum;
        logic        sums_match;
    } i2cee_res_t;

endpackage

// File: rtl/core/i2cee_cfg.sv
// configuration register file of the i2c eeprom master
module i2cee_cfg
    import i2cee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output i2cee_cfg_t  cfg
);

    i2cee_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.word_address   <= RST_WORD_ADDRESS;
            cfg_reg.single_byte    <= RST_SINGLE_BYTE;
            cfg_reg.page_data[0]   <= RST_PAGE_BYTE0;
            cfg_reg.page_data[1]   <= RST_PAGE_BYTE1;
            cfg_reg.page_data[2]   <= RST_PAGE_BYTE2;
            cfg_reg.page_data[3]   <= RST_PAGE_BYTE3;
            cfg_reg.page_data[4]   <= RST_PAGE_BYTE4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                REG_WORD_ADDRESS:   cfg_reg.word_address   <= cfg_data;
                REG_SINGLE_BYTE:    cfg_reg.single_byte    <= cfg_data;
                REG_PAGE_BYTE0:     cfg_reg.page_data[0]   <= cfg_data;
                REG_PAGE_BYTE1:     cfg_reg.page_data[1]   <= cfg_data;
                REG_PAGE_BYTE2:     cfg_reg.page_data[2]   <= cfg_data;
                REG_PAGE_BYTE3:     cfg_reg.page_data[3]   <= cfg_data;
                REG_PAGE_BYTE4:     cfg_reg.page_data[4]   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/i2cee_engine.sv
// bus sequencer: phase, quarter and bit state, advanced one tick per step
module i2cee_engine
    import i2cee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [2:0]  command,
    input  logic        sda_in,
    input  i2cee_cfg_t  cfg,
    output i2cee_res_t  res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_DEVW, PH_ACK_DEVW, PH_WADDR, PH_ACK_WADDR,
        PH_DATA, PH_ACK_DATA, PH_START2, PH_DEVR, PH_ACK_DEVR, PH_READ,
        PH_MACK, PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  quarter_reg, quarter_next;
    logic [2:0]  bit_reg, bit_next;
    logic [2:0]  byte_reg, byte_next;
    logic [7:0]  shifter_reg, shifter_next;
    logic [2:0]  cur_reg, cur_next;
    logic [15:0] write_reg, write_next;
    logic [15:0] read_reg, read_next;
    logic        nack_reg, nack_next;

    logic        start;
    phase_t      ph;
    logic [1:0]  q;
    logic [2:0]  bc;
    logic [2:0]  byc;
    logic        wrbit;
    logic        ack;
    logic        read_last;
    logic        more_pages;
    logic [7:0]  sh_in;
    logic [7:0]  load_byte;
    logic [2:0]  load_idx;

    always_comb
    begin
        start = (phase_reg == PH_IDLE) &&
                (command inside {CMD_BYTE_WRITE, CMD_PAGE_WRITE, CMD_RAND_READ, CMD_SEQ_READ});
        ph        = start ? PH_START1 : phase_reg;
        q         = start ? 2'd0 : quarter_reg;
        bc        = start ? 3'd0 : bit_reg;
        byc       = start ? 3'd0 : byte_reg;
        cur_next  = start ? command : cur_reg;
        nack_next = start ? 1'b0 : nack_reg;

        phase_next   = ph;
        quarter_next = q;
        bit_next     = bc;
        byte_next    = byc;
        shifter_next = shifter_reg;
        write_next   = write_reg;
        read_next    = read_reg;

        wrbit = (ph == PH_DEVW) || (ph == PH_WADDR) || (ph == PH_DATA) || (ph == PH_DEVR);
        ack   = (ph == PH_ACK_DEVW) || (ph == PH_ACK_WADDR) ||
                (ph == PH_ACK_DATA) || (ph == PH_ACK_DEVR);
        read_last  = (cur_next != CMD_SEQ_READ) ||
                     ({1'b0, byc} + 4'd1 >= 4'(PAGE_BYTES));
        more_pages = (cur_next == CMD_PAGE_WRITE) &&
                     ({1'b0, byc} + 4'd1 < 4'(PAGE_BYTES));
        sh_in = {shifter_reg[6:0], sda_in};

        // byte for the next data phase: first page byte, next page byte or single byte
        load_idx  = (ph == PH_ACK_DATA) ? (byc + 3'd1) : 3'd0;
        load_byte = cfg.single_byte;
        if (cur_next == CMD_PAGE_WRITE)
        begin
            load_byte = (load_idx < 3'(PAGE_BYTES)) ? cfg.page_data[load_idx] : 8'd0;
        end

        res = '0;
        res.scl_level = 1'b1;

        if (ph != PH_IDLE)
        begin
            res.busy_res  = 1'b1;
            res.scl_level = (q == 2'd1) || (q == 2'd2);
            if (ph == PH_START1 || ph == PH_START2)
            begin
                res.sda_pull_low = q[1];
            end
            else if (ph == PH_STOP)
            begin
                res.scl_level    = (q != 2'd0);
                res.sda_pull_low = !q[1];
            end
            else if (wrbit)
            begin
                res.sda_pull_low = !shifter_reg[7];
            end
            else if (ack)
            begin
                if (q == 2'd2 && sda_in)
                begin
                    nack_next = 1'b1;
                end
            end
            else if (ph == PH_READ)
            begin
                if (q == 2'd2)
                begin
                    shifter_next = sh_in;
                    if (bc == 3'd7)
                    begin
                        res.read_valid = 1'b1;
                        res.read_byte  = sh_in;
                        res.read_index = byc;
                        if (cur_next == CMD_SEQ_READ)
                        begin
                            read_next = read_reg + {8'd0, sh_in};
                        end
                    end
                end
            end
            else if (ph == PH_MACK)
            begin
                res.sda_pull_low = !read_last;
            end

            if (q != 2'd3)
            begin
                quarter_next = q + 2'd1;
            end
            else
            begin
                quarter_next = 2'd0;
                if (wrbit || ph == PH_READ)
                begin
                    if (bc != 3'd7)
                    begin
                        bit_next = bc + 3'd1;
                        if (wrbit)
                        begin
                            shifter_next = {shifter_reg[6:0], 1'b0};
                        end
                    end
                    else
                    begin
                        bit_next   = 3'd0;
                        phase_next = (ph == PH_READ) ? PH_MACK : phase_t'(ph + 4'd1);
                    end
                end
                else
                begin
                    case (ph)
                        PH_START1:
                        begin
                            shifter_next = {cfg.device_address, 1'b0};
                            phase_next   = PH_DEVW;
                        end
                        PH_ACK_DEVW:
                        begin
                            shifter_next = cfg.word_address;
                            phase_next   = PH_WADDR;
                        end
                        PH_ACK_WADDR:
                        begin
                            if (cur_next == CMD_BYTE_WRITE || cur_next == CMD_PAGE_WRITE)
                            begin
                                byte_next    = 3'd0;
                                shifter_next = load_byte;
                                if (cur_next == CMD_PAGE_WRITE)
                                begin
                                    write_next = write_reg + {8'd0, load_byte};
                                end
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_START2;
                            end
                        end
                        PH_ACK_DATA:
                        begin
                            if (more_pages)
                            begin
                                byte_next    = byc + 3'd1;
                                shifter_next = load_byte;
                                write_next   = write_reg + {8'd0, load_byte};
                                phase_next   = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_START2:
                        begin
                            shifter_next = {cfg.device_address, 1'b1};
                            phase_next   = PH_DEVR;
                        end
                        PH_ACK_DEVR:
                        begin
                            byte_next    = 3'd0;
                            shifter_next = 8'd0;
                            bit_next     = 3'd0;
                            phase_next   = PH_READ;
                        end
                        PH_MACK:
                        begin
                            if (read_last)
                            begin
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                byte_next    = byc + 3'd1;
                                shifter_next = 8'd0;
                                phase_next   = PH_READ;
                            end
                        end
                        PH_STOP:
                        begin
                            res.done_res = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        res.ack_missing = nack_next;
        res.write_sum   = write_next;
        res.read_sum    = read_next;
        res.sums_match  = (write_next == read_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            quarter_reg <= 2'd0;
            bit_reg     <= 3'd0;
            byte_reg    <= 3'd0;
            shifter_reg <= 8'd0;
            cur_reg     <= CMD_NONE;
            write_reg   <= 16'd0;
            read_reg    <= 16'd0;
            nack_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            quarter_reg <= quarter_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shifter_reg <= shifter_next;
            cur_reg     <= cur_next;
            write_reg   <= write_next;
            read_reg    <= read_next;
            nack_reg    <= nack_next;
        end
    end

`ifndef NO_ASSERTIONS
    // an idle bus always restarts a transaction at the first quarter
    a_idle_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> quarter_reg == 2'd0 && bit_reg == 3'd0)
        else $error("idle with nonzero quarter or bit count");

    // byte index always stays below the page size
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_reg < 3'(PAGE_BYTES))
        else $error("byte counter out of range");

    // sums only move on a step
    a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(write_reg) && $stable(read_reg))
        else $error("sums changed without a step");
`endif

endmodule

// File: rtl/core/i2c_eeprom_master_top.sv
// top level of the i2c eeprom master: input register, sequencer, result register
//
// One input transfer is one quarter-bit tick of the bus: a command code and
// the sampled SDA level. Every input transfer yields exactly one result
// transfer with the SCL level and SDA pull-down to drive for that tick, plus
// busy/done, the received byte strobe, the sticky missing-ACK flag and the
// two running byte sums.
// Commands 1 to 4 start a transaction only while the bus is idle; any command
// seen while busy, and codes 0 and 5 to 7, are ignored.
// Each tick is captured in the input register, stepped through the sequencer
// into the result register and is valid there. Throughput is one tick per clock
// while the receiver does not stall, limited only by the single sequencer step
// between input and result register.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_ready drops; nothing is lost or repeated.
// Configuration writes take effect at the clock edge of cfg_we and should be
// made only while the bus is idle.
// Reset (rst_n low, asynchronous) empties both registers, returns the bus to
// idle, clears the sums and the flag and loads the register defaults.
module i2c_eeprom_master_top
    import i2cee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic [2:0]  read_index,
    output logic        ack_missing,
    output logic [15:0] write_sum,
    output logic [15:0] read_sum,
    output logic        sums_match
);

    i2cee_cfg_t cfg;
    i2cee_res_t step_res;
    i2cee_res_t res_reg;

    logic       in_v_reg;
    logic [2:0] cmd_reg;
    logic       sda_reg;
    logic       out_v_reg;
    logic       advance;

    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= command;
            sda_reg <= sda_in;
        end
    end

    i2cee_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cee_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .command (cmd_reg),
        .sda_in  (sda_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid    = out_v_reg;
    assign scl_level    = res_reg.scl_level;
    assign sda_pull_low = res_reg.sda_pull_low;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign read_byte    = res_reg.read_byte;
    assign read_valid   = res_reg.read_valid;
    assign read_index   = res_reg.read_index;
    assign ack_missing  = res_reg.ack_missing;
    assign write_sum    = res_reg.write_sum;
    assign read_sum     = res_reg.read_sum;
    assign sums_match   = res_reg.sums_match;

`ifndef NO_ASSERTIONS
    // stop completes with scl high and sda released
    a_done_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res && scl_level && !sda_pull_low)
        else $error("done without a clean stop condition");

    // read bits are captured only while scl is high and sda is released
    a_read_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> scl_level && !sda_pull_low && busy_res)
        else $error("read byte completed outside a high scl read slot");

    // no stale read data without the strobe
    a_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_byte == 8'd0 && read_index == 3'd0)
        else $error("read fields nonzero without read_valid");

    // a tick is only stepped when the result register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule
